### rtl/core/lge_pkg.sv
// Shared constants, codes and controller/datapath interface types for the life grid engine.
`default_nettype none

package lge_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 7;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// Register word index (paddr bit 2)
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_STEP  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_FETCH,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic req_load;
		logic cell_do;
		logic step_first;
		logic fetch;
		logic calc;
		logic resp_step;
	} lge_cmd_t;

	typedef struct packed {
		logic rows_empty;
		logic last_row;
	} lge_stat_t;

endpackage

`default_nettype wire

### rtl/core/lge_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/lge_ctrl.sv
// Controller state machine: sequences cell accesses and the row walk of a generation step.
`default_nettype none

module lge_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       mode,
	input  wire lge_pkg::lge_stat_t stat,
	output lge_pkg::lge_cmd_t     cmd,
	output logic                  busy
);

	import lge_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == MODE_STEP) begin
						if (stat.rows_empty) begin
							cmd.resp_step = 1'b1;
						end else begin
							cmd.step_first = 1'b1;
							state_d        = ST_FETCH;
						end
					end else begin
						cmd.req_load = 1'b1;
						state_d      = ST_CELL;
					end
				end
			end
			ST_CELL: begin
				cmd.cell_do = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				if (stat.last_row) begin
					cmd.resp_step = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/lge_dpath.sv
// Datapath: grid memory, row-valid bits, row window and B3/S23 next-generation logic.
`default_nettype none

module lge_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lge_pkg::lge_cmd_t            cmd,
	output lge_pkg::lge_stat_t                stat,
	input  wire logic [1:0]                   mode,
	input  wire logic [lge_pkg::COL_W-1:0]    cell_col,
	input  wire logic [lge_pkg::ROW_W-1:0]    cell_row,
	input  wire logic                         new_alive,
	input  wire logic [lge_pkg::SIZE_W-1:0]   grid_columns,
	input  wire logic [lge_pkg::SIZE_W-1:0]   grid_rows,
	output logic                              done,
	output logic                              alive_out,
	output logic                              in_range
);

	import lge_pkg::*;

	logic [1:0]          mode_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                val_q;
	logic [ROW_W-1:0]    y_q;
	logic [MAX_COLS-1:0] above_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_ROWS-1:0] valid_q;
	logic                rvalid_s1;
	logic                done_q;
	logic                alive_q;
	logic                in_range_q;

	logic [SIZE_W-1:0]   used_cols;
	logic [SIZE_W-1:0]   used_rows;
	logic [MAX_COLS-1:0] mask;
	logic                in_area;
	logic [ROW_W-1:0]    rd_addr;
	logic [MAX_COLS-1:0] ram_rdata;
	logic [MAX_COLS-1:0] rd_row;
	logic [MAX_COLS-1:0] below;
	logic [MAX_COLS-1:0] next_gen;
	logic                have_below;
	logic                we;
	logic [ROW_W-1:0]    waddr;
	logic [MAX_COLS-1:0] wdata;
	logic [MAX_COLS-1:0] cell_word;

	assign used_cols = (grid_columns > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : grid_columns;
	assign used_rows = (grid_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : grid_rows;

	always_comb begin
		for (int x = 0; x < MAX_COLS; x++) begin
			mask[x] = (SIZE_W'(x) < used_cols);
		end
	end

	assign in_area = (SIZE_W'(col_q) < used_cols) && (SIZE_W'(row_q) < used_rows);

	assign have_below = (SIZE_W'(y_q) + SIZE_W'(1)) < used_rows;

	assign stat.rows_empty = (used_rows == '0);
	assign stat.last_row   = !have_below;

	// Read row 0 at step start, the row below during fetch, two ahead while walking
	always_comb begin
		if (cmd.step_first) begin
			rd_addr = '0;
		end else if (cmd.fetch) begin
			rd_addr = y_q + ROW_W'(1);
		end else if (cmd.calc) begin
			rd_addr = y_q + ROW_W'(2);
		end else begin
			rd_addr = cell_row;
		end
	end

	assign rd_row = rvalid_s1 ? ram_rdata : '0;
	assign below  = have_below ? rd_row : '0;

	// B3/S23 over the masked window, cells past either edge count as dead
	always_comb begin
		logic [MAX_COLS+1:0] a_ext;
		logic [MAX_COLS+1:0] c_ext;
		logic [MAX_COLS+1:0] b_ext;
		logic [3:0]          cnt;
		a_ext = {1'b0, above_q & mask, 1'b0};
		c_ext = {1'b0, cur_q & mask, 1'b0};
		b_ext = {1'b0, below & mask, 1'b0};
		for (int x = 0; x < MAX_COLS; x++) begin
			cnt = 4'(a_ext[x]) + 4'(a_ext[x+1]) + 4'(a_ext[x+2])
			    + 4'(c_ext[x]) + 4'(c_ext[x+2])
			    + 4'(b_ext[x]) + 4'(b_ext[x+1]) + 4'(b_ext[x+2]);
			next_gen[x] = (cnt == 4'd3) || (c_ext[x+1] && (cnt == 4'd2));
		end
	end

	always_comb begin
		cell_word         = rd_row;
		cell_word[col_q]  = val_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = row_q;
		wdata = cell_word;
		if (cmd.calc) begin
			we    = 1'b1;
			waddr = y_q;
			wdata = (next_gen & mask) | (cur_q & ~mask);
		end else if (cmd.cell_do && (mode_q == MODE_WRITE) && in_area) begin
			we = 1'b1;
		end
	end

	lge_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[rd_addr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			done_q <= cmd.cell_do | cmd.resp_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			mode_q <= mode;
			col_q  <= cell_col;
			row_q  <= cell_row;
			val_q  <= new_alive;
		end
		if (cmd.step_first) begin
			y_q <= '0;
		end else if (cmd.calc) begin
			y_q <= y_q + ROW_W'(1);
		end
		if (cmd.fetch) begin
			above_q <= '0;
			cur_q   <= rd_row;
		end else if (cmd.calc) begin
			above_q <= cur_q;
			cur_q   <= below;
		end
		if (cmd.cell_do) begin
			alive_q    <= (mode_q == MODE_READ) && in_area && rd_row[col_q];
			in_range_q <= in_area && ((mode_q == MODE_WRITE) || (mode_q == MODE_READ));
		end else if (cmd.resp_step) begin
			alive_q    <= 1'b0;
			in_range_q <= 1'b1;
		end
	end

	assign done      = done_q;
	assign alive_out = alive_q;
	assign in_range  = in_range_q;

endmodule

`default_nettype wire

### rtl/core/life_grid_engine.sv
// Top level of the life grid engine: APB register file, controller and datapath.
`default_nettype none

// Bounded Game of Life grid (B3/S23), up to 64 x 64 cells, one row word per memory entry.
// Request channel: present mode, cell_col, cell_row and new_alive with start high; the
//   request is taken at the edge where start is high and busy is low.
//   mode write stores one cell, mode read returns one, mode step advances a generation.
// Result channel: done pulses for exactly one cycle with alive_out and in_range valid.
//   The receiver cannot stall; the result is gone after that cycle.
// Sequencing:
//   read/write: one memory read, then the read-modify-write, then done is registered;
//     a new request is taken once the engine is idle again.
//   step: a fetch of row 0, then one row per cycle through the single-port-pair grid
//     memory; done follows the last used row; with zero used rows, done is registered
//     straight from the request and the engine stays free.
// Configuration: APB, grid_columns at 0x0 and grid_rows at 0x4, 7 bits each, reset 64;
//   values above 64 act as 64. Write them only while the engine is idle.
// Reset: arst_n clears the controller, the result strobe and the per-row valid bits;
//   a row never written since reset reads as all dead, so no clearing pass is needed.
module life_grid_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   mode,
	input  wire logic [lge_pkg::COL_W-1:0]    cell_col,
	input  wire logic [lge_pkg::ROW_W-1:0]    cell_row,
	input  wire logic                         new_alive,
	output logic                              done,
	output logic                              alive_out,
	output logic                              in_range,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lge_pkg::APB_AW-1:0]   paddr,
	input  wire logic [lge_pkg::APB_DW-1:0]   pwdata,
	output logic      [lge_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);

	import lge_pkg::*;

	logic [SIZE_W-1:0] grid_columns_q;
	logic [SIZE_W-1:0] grid_rows_q;
	lge_cmd_t          cmd;
	lge_stat_t         stat;

	assign pready = 1'b1;

	// Register write on the access phase; only the word index bit decodes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= SIZE_W'(MAX_COLS);
			grid_rows_q    <= SIZE_W'(MAX_ROWS);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_COLS: grid_columns_q <= pwdata[SIZE_W-1:0];
				REG_ROWS: grid_rows_q    <= pwdata[SIZE_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_COLS: prdata = APB_DW'(grid_columns_q);
			REG_ROWS: prdata = APB_DW'(grid_rows_q);
			default:  prdata = '0;
		endcase
	end

	// Controller sequences cell accesses and the row walk
	lge_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath holds the grid memory and produces the result
	lge_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.new_alive    (new_alive),
		.grid_columns (grid_columns_q),
		.grid_rows    (grid_rows_q),
		.done         (done),
		.alive_out    (alive_out),
		.in_range     (in_range)
	);

endmodule

`default_nettype wire
